// File: design/shidx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted hash index table.
// Depends on nothing; shidx_ctrl and the top level refer to it by scoped names.
package shidx_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths fixed by the interface
  localparam int KEY_W    = 64;
  localparam int REC_W    = 32;
  localparam int ENT_W    = KEY_W + REC_W;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 10;
  localparam int USED_W   = 11;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_INSERT = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  // Result handed from the sequencer to the port stage
  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [IDX_W-1:0] position;
    logic [REC_W-1:0] record;
    logic [CNT_W-1:0] used;
  } res_t;

  // Memory request from the sequencer, entry = {key, record}
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// File: design/shidx_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module shidx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, and a registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/shidx_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: binary search over the entry memory, shift-up insert, lookup check.
// Depends on shidx_pkg; drives the entry memory through a mem_req_t.
module shidx_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          act,
  input  logic [shidx_pkg::KEY_W-1:0]   key,
  input  logic [shidx_pkg::REC_W-1:0]   rec,
  output logic                          busy,
  output shidx_pkg::mem_req_t           mem_req,
  input  logic [shidx_pkg::ENT_W-1:0]   mem_rd_data,
  output shidx_pkg::res_t               res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_CHK,
    ST_SHIFT
  } state_t;

  state_t                          state_r, state_nxt;
  shidx_pkg::action_t              act_r, act_nxt;
  logic [shidx_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [shidx_pkg::REC_W-1:0]     rec_r, rec_nxt;
  logic [shidx_pkg::CNT_W-1:0]     lo_r, lo_nxt;
  logic [shidx_pkg::CNT_W-1:0]     hi_r, hi_nxt;
  logic [shidx_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [shidx_pkg::IDX_W-1:0]     pos_r, pos_nxt;
  logic                            pend_r, pend_nxt;
  logic [shidx_pkg::IDX_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic [shidx_pkg::CNT_W-1:0]     count_r, count_nxt;
  shidx_pkg::res_t                 res_r, res_nxt;

  logic [shidx_pkg::CNT_W-1:0]     mid;
  logic [shidx_pkg::KEY_W-1:0]     rd_key;
  logic [shidx_pkg::REC_W-1:0]     rd_rec;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_key = mem_rd_data[shidx_pkg::ENT_W-1:shidx_pkg::REC_W];
  assign rd_rec = mem_rd_data[shidx_pkg::REC_W-1:0];
  assign busy   = (state_r != ST_IDLE);
  assign res    = res_r;

  // Next-state and memory request
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    key_nxt       = key_r;
    rec_nxt       = rec_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    count_nxt     = count_r;
    res_nxt       = '0;
    res_nxt.used  = count_r;
    mem_req         = '0;
    mem_req.wr_addr = pend_addr_r;
    mem_req.wr_data = mem_rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt = shidx_pkg::action_t'(act);
          key_nxt = key;
          rec_nxt = rec;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          // Insert into a full table: report and change nothing
          if (act == shidx_pkg::ACT_INSERT &&
              count_r == shidx_pkg::CNT_W'(shidx_pkg::TABLE_DEPTH)) begin
            res_nxt.valid  = 1'b1;
            res_nxt.status = shidx_pkg::STAT_FULL;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end

      ST_SRCH: begin
        if (lo_r < hi_r) begin
          // Fetch the midpoint for comparison
          mem_req.rd_addr = mid[shidx_pkg::IDX_W-1:0];
          idx_nxt         = mid[shidx_pkg::IDX_W-1:0];
          state_nxt       = ST_CMP;
        end else if (act_r == shidx_pkg::ACT_INSERT) begin
          // Start shifting from the top entry down to the insert point
          idx_nxt   = count_r[shidx_pkg::IDX_W-1:0];
          pos_nxt   = lo_r[shidx_pkg::IDX_W-1:0];
          state_nxt = ST_SHIFT;
        end else if (lo_r < count_r) begin
          mem_req.rd_addr = lo_r[shidx_pkg::IDX_W-1:0];
          state_nxt       = ST_CHK;
        end else begin
          res_nxt.valid  = 1'b1;
          res_nxt.status = shidx_pkg::STAT_NOT_FOUND;
          state_nxt      = ST_IDLE;
        end
      end

      ST_CMP: begin
        // Narrow the search window
        if (rd_key < key_r) begin
          lo_nxt = {1'b0, idx_r} + shidx_pkg::CNT_W'(1);
        end else begin
          hi_nxt = {1'b0, idx_r};
        end
        state_nxt = ST_SRCH;
      end

      ST_CHK: begin
        res_nxt.valid = 1'b1;
        if (rd_key == key_r) begin
          res_nxt.status   = shidx_pkg::STAT_OK;
          res_nxt.position = lo_r[shidx_pkg::IDX_W-1:0];
          res_nxt.record   = rd_rec;
        end else begin
          res_nxt.status = shidx_pkg::STAT_NOT_FOUND;
        end
        state_nxt = ST_IDLE;
      end

      ST_SHIFT: begin
        // Land the entry read last cycle one place higher
        pend_nxt = 1'b0;
        if (pend_r) begin
          mem_req.wr_en = 1'b1;
        end
        if (idx_r != pos_r) begin
          mem_req.rd_addr = idx_r - shidx_pkg::IDX_W'(1);
          pend_nxt        = 1'b1;
          pend_addr_nxt   = idx_r;
          idx_nxt         = idx_r - shidx_pkg::IDX_W'(1);
        end else if (!pend_r) begin
          // Write the new entry into the opened slot
          mem_req.wr_en    = 1'b1;
          mem_req.wr_addr  = pos_r;
          mem_req.wr_data  = {key_r, rec_r};
          count_nxt        = count_r + shidx_pkg::CNT_W'(1);
          res_nxt.valid    = 1'b1;
          res_nxt.status   = shidx_pkg::STAT_OK;
          res_nxt.position = pos_r;
          res_nxt.used     = count_r + shidx_pkg::CNT_W'(1);
          state_nxt        = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, working registers and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      count_r <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      res_r   <= res_nxt;
    end
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    rec_r       <= rec_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

endmodule

// File: design/sorted_hash_index_table_unit.sv
`timescale 1ns / 1ps
// Top level of the sorted hash index table: sequencer plus one entry memory.
// Depends on shidx_pkg, shidx_ram and shidx_ctrl.
//
//  channel | ports                                          | transfer
//  --------+------------------------------------------------+----------------------
//  input   | in_action, in_key_hash, in_record_ref          | start && !busy
//  result  | out_status, out_position, out_found_record,    | out_valid, one cycle
//          | out_entries_used                               |
//
// Steps: each halving of the binary search reads the midpoint from memory, then
// compares it. A lookup adds the final entry check and result. An insert then
// moves each entry above the insert point one place up (one read and one write
// port on the entry memory) and writes the new entry into the opened slot.
// A full-table insert answers without leaving the idle state. Reset clears the
// state, the count and the result; the memory needs no clearing. The result
// shows in the cycle after the last step and cannot be stalled.
module sorted_hash_index_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [shidx_pkg::KEY_W-1:0]    in_key_hash,
  input  logic [shidx_pkg::REC_W-1:0]    in_record_ref,
  output logic                           out_valid,
  output logic [shidx_pkg::STATUS_W-1:0] out_status,
  output logic [shidx_pkg::POS_W-1:0]    out_position,
  output logic [shidx_pkg::REC_W-1:0]    out_found_record,
  output logic [shidx_pkg::USED_W-1:0]   out_entries_used
);

  shidx_pkg::mem_req_t             mem_req;
  logic [shidx_pkg::ENT_W-1:0]     mem_rd_data;
  shidx_pkg::res_t                 res;

  // Sequencer
  shidx_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .act         (in_action),
    .key         (in_key_hash),
    .rec         (in_record_ref),
    .busy        (busy),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res         (res)
  );

  // Entry memory, each word is {key, record}
  shidx_ram #(
    .WIDTH (shidx_pkg::ENT_W),
    .DEPTH (shidx_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

  // Map the registered result onto the ports
  assign out_valid        = res.valid;
  assign out_status       = res.status;
  assign out_position     = shidx_pkg::POS_W'(res.position);
  assign out_found_record = res.record;
  assign out_entries_used = shidx_pkg::USED_W'(res.used);

`ifndef ASSERT_OFF
  // An accepted item, other than an insert into a full table, keeps the block busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !(in_action == shidx_pkg::ACT_INSERT &&
     res.used == shidx_pkg::CNT_W'(shidx_pkg::TABLE_DEPTH))) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result only shows once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A full report only comes from a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == shidx_pkg::STAT_FULL) |->
    (res.used == shidx_pkg::CNT_W'(shidx_pkg::TABLE_DEPTH)))
    else $error("table full reported below depth");

  // A miss or a full report carries no position and no record
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != shidx_pkg::STAT_OK) |->
    (out_position == '0 && out_found_record == '0))
    else $error("failed result carries data");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for sorted_hash_index_table_unit: a scoreboard that mirrors the sorted table,
// plus directed and random traffic.
// Depends on shidx_pkg and the design files of sorted_hash_index_table_unit.

import shidx_pkg::*;

// One expected answer of the table
typedef struct {
  status_t           status;
  logic [POS_W-1:0]  position;
  logic [REC_W-1:0]  record;
  logic [USED_W-1:0] used;
} table_answer_t;

class index_table_scoreboard;
  logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
  logic [REC_W-1:0] rec_mirror [TABLE_DEPTH];
  int unsigned      entries;
  table_answer_t    answers_due [$];
  int unsigned      mismatches;
  int unsigned      n_checked, n_hits, n_misses, n_inserts, n_rejects;

  function new();
    entries    = 0;
    mismatches = 0;
    n_checked  = 0;
    n_hits     = 0;
    n_misses   = 0;
    n_inserts  = 0;
    n_rejects  = 0;
  endfunction

  // First slot whose key is not below the given key, or the entry count
  function int unsigned first_not_below(logic [KEY_W-1:0] key);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key_mirror[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one accepted request to the mirror and queue its answer
  function void note_transfer(action_t act, logic [KEY_W-1:0] key, logic [REC_W-1:0] rec);
    table_answer_t ans;
    int unsigned   slot;
    int unsigned   i;
    ans.status   = STAT_OK;
    ans.position = '0;
    ans.record   = '0;
    if (act == ACT_INSERT) begin
      if (entries >= TABLE_DEPTH) begin
        ans.status = STAT_FULL;
        n_rejects++;
      end else begin
        slot = first_not_below(key);
        // shift the upper part one slot up, then drop the new entry in
        for (i = entries; i > slot; i--) begin
          key_mirror[i] = key_mirror[i - 1];
          rec_mirror[i] = rec_mirror[i - 1];
        end
        key_mirror[slot] = key;
        rec_mirror[slot] = rec;
        ans.position     = POS_W'(slot);
        entries++;
        n_inserts++;
      end
    end else begin
      slot = first_not_below(key);
      if (slot < entries && key_mirror[slot] == key) begin
        ans.position = POS_W'(slot);
        ans.record   = rec_mirror[slot];
        n_hits++;
      end else begin
        ans.status = STAT_NOT_FOUND;
        n_misses++;
      end
    end
    ans.used = USED_W'(entries);
    answers_due.push_back(ans);
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Compare one result transfer against the oldest expected answer
  task check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                    logic [REC_W-1:0] record, logic [USED_W-1:0] used);
    table_answer_t ans;
    if (answers_due.size() == 0) begin
      report("unexpected result, status", status, 0);
    end else begin
      ans = answers_due.pop_front();
      n_checked++;
      if (status !== ans.status) report("status", status, ans.status);
      if (position !== ans.position) report("position", position, ans.position);
      if (record !== ans.record) report("found_record", record, ans.record);
      if (used !== ans.used) report("entries_used", used, ans.used);
    end
  endtask
endclass

module tb;
  localparam int RANDOM_ITEMS = 558;
  localparam int STALL_LIMIT  = 8000;
  localparam int TAIL_CYCLES  = 60;
  localparam logic [KEY_W-1:0] FILL_BASE = 64'hF000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_ONES  = '1;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic                in_action     = 1'b0;
  logic [KEY_W-1:0]    in_key_hash   = '0;
  logic [REC_W-1:0]    in_record_ref = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;
  logic [REC_W-1:0]    out_found_record;
  logic [USED_W-1:0]   out_entries_used;

  index_table_scoreboard sb;
  bit                    idle_on = 1'b1;
  int                    stall_cycles = 0;

  sorted_hash_index_table_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_key_hash      (in_key_hash),
    .in_record_ref    (in_record_ref),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_position     (out_position),
    .out_found_record (out_found_record),
    .out_entries_used (out_entries_used)
  );

  always #1 clk = ~clk;

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_status, out_position, out_found_record, out_entries_used);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL sorted_hash_index_table_unit");
        $finish;
      end
    end
  end

  // Random key below the fill region
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k     = {$urandom, $urandom};
    k[60] = 1'b0;
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    return sb.key_mirror[$urandom_range(0, sb.entries - 1)];
  endfunction

  // Present one request, hold it until the transfer, then log it
  task send_request(action_t act, logic [KEY_W-1:0] key, logic [REC_W-1:0] rec);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_action     <= act;
    in_key_hash   <= key;
    in_record_ref <= rec;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(act, key, rec);
  endtask

  // Hold off the sender until every answer is back
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int               n;
    int               r;
    logic [KEY_W-1:0] key;

    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, equal keys, misses on both sides
    send_request(ACT_LOOKUP, '0, '0);
    send_request(ACT_LOOKUP, KEY_ONES, '1);
    send_request(ACT_INSERT, 64'd5000, 32'hA5A5_A5A5);
    send_request(ACT_INSERT, '0, '0);
    send_request(ACT_INSERT, KEY_ONES, '1);
    send_request(ACT_INSERT, KEY_ONES, 32'h1234_5678);
    send_request(ACT_INSERT, 64'd5000, 32'd1);
    send_request(ACT_INSERT, 64'd5000, 32'd2);
    send_request(ACT_LOOKUP, 64'd5000, '0);
    send_request(ACT_LOOKUP, KEY_ONES, '0);
    send_request(ACT_LOOKUP, '0, '1);
    send_request(ACT_LOOKUP, 64'd4999, '0);
    send_request(ACT_LOOKUP, 64'd5001, '0);
    send_request(ACT_LOOKUP, KEY_ONES - 1, '0);
    send_request(ACT_INSERT, 64'd1, 32'h5A5A_5A5A);
    send_request(ACT_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0001);
    send_request(ACT_LOOKUP, 64'd1, '0);
    send_request(ACT_LOOKUP, 64'h8000_0000_0000_0000, '0);
    drain();

    // Random: inserts with many duplicates, lookups mostly of stored keys
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (n % 150 == 149) drain();
      r = $urandom_range(0, 99);
      if (sb.entries == 0 || $urandom_range(0, 99) < 55) begin
        if (r < 25 && sb.entries > 0) key = stored_key();
        else if (r < 30) key = KEY_W'($urandom_range(0, 3));
        else key = rand_key();
        send_request(ACT_INSERT, key, $urandom);
      end else begin
        if (r < 60) key = stored_key();
        else if (r < 75) key = stored_key() + (r[0] ? 64'd1 : -64'd1);
        else key = rand_key();
        send_request(ACT_LOOKUP, key, $urandom);
      end
    end
    drain();

    // Lookups at both ends of the table, in the middle and a miss
    idle_on = 1'b1;
    send_request(ACT_LOOKUP, sb.key_mirror[0], '0);
    send_request(ACT_LOOKUP, sb.key_mirror[sb.entries - 1], '0);
    send_request(ACT_LOOKUP, sb.key_mirror[sb.entries / 2], '0);
    send_request(ACT_LOOKUP, FILL_BASE - 1, '0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.answers_due.size() != 0)
      sb.report("answers never returned", sb.answers_due.size(), 0);
    $display("checked %0d results: %0d inserts, %0d rejected on a full table,",
             sb.n_checked, sb.n_inserts, sb.n_rejects);
    $display("%0d lookup hits, %0d lookup misses, %0d mismatches",
             sb.n_hits, sb.n_misses, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS sorted_hash_index_table_unit");
    end else begin
      $display("FAIL sorted_hash_index_table_unit");
    end
    $finish;
  end
endmodule
